>>> sv/plbbl_pkg.sv
// Shared types and constants for the partitioned LRU tile list.
// No dependencies; every other file of the block imports this package.
package plbbl_pkg;

	localparam int DEF_ENTRIES  = 64;
	localparam int DEF_USERS    = 16;
	localparam int DEF_KEY_BITS = 32;

	localparam int MODE_W  = 3;
	localparam int KEY_W   = 32;
	localparam int BYTES_W = 32;
	localparam int USER_W  = 4;
	localparam int TOTAL_W = 38;
	localparam int CNT_W   = 7;
	localparam int STAT_W  = 2;

	localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MARK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FREE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DROP  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [KEY_W-1:0]   tile_key;
		logic [BYTES_W-1:0] tile_bytes;
		logic [USER_W-1:0]  user_id;
		logic [TOTAL_W-1:0] byte_budget;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic               evicted_valid;
		logic [KEY_W-1:0]   evicted_key;
		logic [TOTAL_W-1:0] total_bytes;
		logic [CNT_W-1:0]   tile_count;
		logic               last;
	} rsp_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN_START,
		OP_SCAN,
		OP_SEL_FREE,
		OP_SEL_HEAD,
		OP_SEL_CL,
		OP_RD_ENTRY,
		OP_SUB_BYTES,
		OP_NEW_ENTRY,
		OP_SET_BYTES,
		OP_MARK_USERS,
		OP_CLR_USERS,
		OP_RELEASE,
		OP_LK_RD,
		OP_DETACH_WR,
		OP_ANC_SENT_AFTER,
		OP_ANC_SENT_BEFORE,
		OP_ANC_TAIL_AFTER,
		OP_LK_RD_ANC,
		OP_INS_W1,
		OP_INS_W2,
		OP_CL_START,
		OP_CL_INC,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [STAT_W-1:0] status;
		logic              evict;
	} ctl_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              hit;
		logic              scan_done;
		logic              free_found;
		logic              node_is_tail;
		logic              users_zero;
		logic              cl_valid;
		logic              cl_last;
		logic              evict_more;
		logic              out_busy;
	} dp_stat_t;

endpackage

>>> sv/plbbl_req_if.sv
// Request channel of the partitioned LRU tile list: valid, ready and one item.
// Depends on plbbl_pkg for the field widths.
interface plbbl_req_if;
	import plbbl_pkg::*;

	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [KEY_W-1:0]   tile_key;
	logic [BYTES_W-1:0] tile_bytes;
	logic [USER_W-1:0]  user_id;
	logic [TOTAL_W-1:0] byte_budget;

	modport source(output valid, mode, tile_key, tile_bytes, user_id, byte_budget,
		input ready);
	modport sink(input valid, mode, tile_key, tile_bytes, user_id, byte_budget,
		output ready);
endinterface

>>> sv/plbbl_rsp_if.sv
// Result channel of the partitioned LRU tile list: valid, ready and one item.
// Depends on plbbl_pkg for the field widths.
interface plbbl_rsp_if;
	import plbbl_pkg::*;

	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic               evicted_valid;
	logic [KEY_W-1:0]   evicted_key;
	logic [TOTAL_W-1:0] total_bytes;
	logic [CNT_W-1:0]   tile_count;
	logic               last;

	modport source(output valid, status, evicted_valid, evicted_key, total_bytes,
		tile_count, last, input ready);
	modport sink(input valid, status, evicted_valid, evicted_key, total_bytes,
		tile_count, last, output ready);
endinterface

>>> sv/plbbl_ctrl.sv
// Sequencer of the partitioned LRU tile list: walks each request through
// search, entry update and link update steps. Depends on plbbl_pkg.
module plbbl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  plbbl_pkg::dp_stat_t stat,
	output plbbl_pkg::ctl_cmd_t cmd
);
	import plbbl_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_SCAN,
		S_ADD_RD, S_ADD_SUB, S_ADD_MISS, S_ADD_NEW, S_ADD_SET, S_ADD_ANC,
		S_MARK_RD, S_MARK_WR, S_MARK_ANC,
		S_DROP_RD, S_DROP_REL,
		S_CL_CHK, S_CL_RD, S_CL_WR, S_CL_ANC, S_CL_NEXT,
		S_FREE_CHK, S_FREE_RD, S_FREE_REL, S_FREE_EMIT,
		S_DET_RD, S_DET_WR, S_INS_RD, S_INS_W1, S_INS_W2,
		S_EMIT_OK, S_EMIT_NF, S_EMIT_FULL
	} state_t;

	state_t state_q, state_d, ret_q, ret_d;

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		in_ready = 1'b0;
		cmd      = '{op: OP_NONE, status: ST_OK, evict: 1'b0};
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.mode)
					MODE_ADD, MODE_MARK, MODE_DROP: begin
						cmd.op  = OP_SCAN_START;
						state_d = S_SCAN;
					end
					MODE_CLEAR: begin
						cmd.op  = OP_CL_START;
						state_d = S_CL_CHK;
					end
					MODE_FREE: state_d = S_FREE_CHK;
					default:   state_d = S_EMIT_OK;
				endcase
			end
			S_SCAN: begin
				cmd.op = OP_SCAN;
				if (stat.hit) begin
					case (stat.mode)
						MODE_ADD:  state_d = S_ADD_RD;
						MODE_MARK: state_d = S_MARK_RD;
						default:   state_d = S_DROP_RD;
					endcase
				end else if (stat.scan_done) begin
					state_d = (stat.mode == MODE_ADD) ? S_ADD_MISS : S_EMIT_NF;
				end
			end
			S_ADD_RD: begin
				cmd.op  = OP_RD_ENTRY;
				state_d = S_ADD_SUB;
			end
			S_ADD_SUB: begin
				cmd.op  = OP_SUB_BYTES;
				state_d = S_DET_RD;
				ret_d   = S_ADD_SET;
			end
			S_ADD_MISS: begin
				if (stat.free_found) begin
					cmd.op  = OP_SEL_FREE;
					state_d = S_ADD_NEW;
				end else begin
					state_d = S_EMIT_FULL;
				end
			end
			S_ADD_NEW: begin
				cmd.op  = OP_NEW_ENTRY;
				state_d = S_ADD_SET;
			end
			S_ADD_SET: begin
				cmd.op  = OP_SET_BYTES;
				state_d = S_ADD_ANC;
			end
			S_ADD_ANC: begin
				cmd.op  = OP_ANC_SENT_AFTER;
				state_d = S_INS_RD;
				ret_d   = S_EMIT_OK;
			end
			S_MARK_RD: begin
				cmd.op  = OP_RD_ENTRY;
				state_d = S_MARK_WR;
			end
			S_MARK_WR: begin
				cmd.op = OP_MARK_USERS;
				if (stat.node_is_tail) begin
					state_d = S_EMIT_OK;
				end else begin
					state_d = S_DET_RD;
					ret_d   = S_MARK_ANC;
				end
			end
			S_MARK_ANC: begin
				cmd.op  = OP_ANC_TAIL_AFTER;
				state_d = S_INS_RD;
				ret_d   = S_EMIT_OK;
			end
			S_DROP_RD: begin
				cmd.op  = OP_RD_ENTRY;
				state_d = S_DET_RD;
				ret_d   = S_DROP_REL;
			end
			S_DROP_REL: begin
				cmd.op  = OP_RELEASE;
				state_d = S_EMIT_OK;
			end
			S_CL_CHK: begin
				if (stat.cl_valid) begin
					cmd.op  = OP_SEL_CL;
					state_d = S_CL_RD;
				end else begin
					state_d = S_CL_NEXT;
				end
			end
			S_CL_RD: begin
				cmd.op  = OP_RD_ENTRY;
				state_d = S_CL_WR;
			end
			S_CL_WR: begin
				cmd.op = OP_CLR_USERS;
				if (stat.users_zero) begin
					state_d = S_DET_RD;
					ret_d   = S_CL_ANC;
				end else begin
					state_d = S_CL_NEXT;
				end
			end
			S_CL_ANC: begin
				cmd.op  = OP_ANC_SENT_BEFORE;
				state_d = S_INS_RD;
				ret_d   = S_CL_NEXT;
			end
			S_CL_NEXT: begin
				if (stat.cl_last) begin
					state_d = S_EMIT_OK;
				end else begin
					cmd.op  = OP_CL_INC;
					state_d = S_CL_CHK;
				end
			end
			S_FREE_CHK: begin
				if (stat.evict_more) begin
					cmd.op  = OP_SEL_HEAD;
					state_d = S_FREE_RD;
				end else begin
					state_d = S_EMIT_OK;
				end
			end
			S_FREE_RD: begin
				cmd.op  = OP_RD_ENTRY;
				state_d = S_DET_RD;
				ret_d   = S_FREE_REL;
			end
			S_FREE_REL: begin
				cmd.op  = OP_RELEASE;
				state_d = S_FREE_EMIT;
			end
			S_FREE_EMIT: begin
				// An eviction result is final when no further eviction is due.
				if (!stat.out_busy) begin
					cmd.op    = OP_EMIT;
					cmd.evict = 1'b1;
					state_d   = stat.evict_more ? S_FREE_CHK : S_IDLE;
				end
			end
			S_DET_RD: begin
				cmd.op  = OP_LK_RD;
				state_d = S_DET_WR;
			end
			S_DET_WR: begin
				cmd.op  = OP_DETACH_WR;
				state_d = ret_q;
			end
			S_INS_RD: begin
				cmd.op  = OP_LK_RD_ANC;
				state_d = S_INS_W1;
			end
			S_INS_W1: begin
				cmd.op  = OP_INS_W1;
				state_d = S_INS_W2;
			end
			S_INS_W2: begin
				cmd.op  = OP_INS_W2;
				state_d = ret_q;
			end
			S_EMIT_OK, S_EMIT_NF, S_EMIT_FULL: begin
				if (!stat.out_busy) begin
					cmd.op     = OP_EMIT;
					cmd.status = (state_q == S_EMIT_NF) ? ST_NOT_FOUND :
						(state_q == S_EMIT_FULL) ? ST_FULL : ST_OK;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end
endmodule

>>> sv/plbbl_dp.sv
// Datapath of the partitioned LRU tile list: entry memories, link memories,
// sentinel links, byte total, tile count and result register. Uses plbbl_pkg.
module plbbl_dp #(
	parameter int ENTRIES  = plbbl_pkg::DEF_ENTRIES,
	parameter int USERS    = plbbl_pkg::DEF_USERS,
	parameter int KEY_BITS = plbbl_pkg::DEF_KEY_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  plbbl_pkg::req_t     req_in,
	input  plbbl_pkg::ctl_cmd_t cmd,
	output plbbl_pkg::dp_stat_t stat,
	output plbbl_pkg::rsp_t     rsp_out,
	output logic                rsp_valid,
	input  logic                rsp_ready
);
	import plbbl_pkg::*;

	localparam int NW  = $clog2(ENTRIES + 2);
	localparam int IW  = $clog2(ENTRIES);
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int KIN = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam logic [NW-1:0] SENT     = NW'(ENTRIES);
	localparam logic [NW-1:0] NIL      = NW'(ENTRIES + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	req_t req_q;

	logic [KEY_BITS-1:0] key_mem [ENTRIES];
	logic [BYTES_W-1:0]  bytes_mem [ENTRIES];
	logic [USERS-1:0]    users_mem [ENTRIES];
	logic [NW-1:0]       prev_mem [ENTRIES];
	logic [NW-1:0]       next_mem [ENTRIES];

	logic [KEY_BITS-1:0] key_rd_q;
	logic [BYTES_W-1:0]  bytes_rd_q;
	logic [USERS-1:0]    users_rd_q;
	logic [NW-1:0]       prv_rd_q, nxt_rd_q;

	logic [ENTRIES-1:0] valid_q;
	logic [NW-1:0]      head_q, tail_q, sent_prev_q, sent_next_q;
	logic [NW-1:0]      node_q, anc_q;
	logic               after_q;
	logic [IW-1:0]      scan_idx_q, scan_s1, free_slot_q, cl_idx_q;
	logic               scan_more_q, s1_act_q, free_found_q;
	logic [TOTAL_W-1:0] total_q;
	logic [CW-1:0]      count_q;
	rsp_t               out_q;
	logic               out_valid_q;

	logic [KEY_BITS-1:0] key_in;
	logic [USERS-1:0]    ubit;
	logic [IW-1:0]       node_idx;
	logic                hit_now, evict_more;
	logic [TOTAL_W-1:0]  sub_res;
	logic                key_re, users_we, lr_en;
	logic [IW-1:0]       key_ra;
	logic [USERS-1:0]    users_wd;
	logic [NW-1:0]       lr_addr;
	logic                pw_en, nw_en;
	logic [NW-1:0]       pw_addr, pw_data, nw_addr, nw_data, head_d, tail_d;

	assign key_in   = KEY_BITS'(req_q.tile_key[KIN-1:0]);
	assign ubit     = (32'(req_q.user_id) < 32'(USERS)) ? (USERS'(1) << req_q.user_id) : '0;
	assign node_idx = node_q[IW-1:0];
	assign hit_now  = (cmd.op == OP_SCAN) && s1_act_q && valid_q[scan_s1] &&
		(key_rd_q == key_in);
	assign evict_more = (total_q > req_q.byte_budget) && (head_q != SENT);
	assign sub_res  = (total_q >= TOTAL_W'(bytes_rd_q)) ?
		total_q - TOTAL_W'(bytes_rd_q) : '0;

	always_comb begin
		stat.mode         = req_q.mode;
		stat.hit          = hit_now;
		stat.scan_done    = s1_act_q && (scan_s1 == LAST_IDX);
		stat.free_found   = free_found_q;
		stat.node_is_tail = (tail_q == node_q);
		stat.users_zero   = ((users_rd_q & ~ubit) == '0);
		stat.cl_valid     = valid_q[cl_idx_q];
		stat.cl_last      = (cl_idx_q == LAST_IDX);
		stat.evict_more   = evict_more;
		stat.out_busy     = out_valid_q && !rsp_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			req_q <= req_in;
		end
	end

	// Entry memories: one write and one registered read port each.
	assign key_re = ((cmd.op == OP_SCAN) && scan_more_q) || (cmd.op == OP_RD_ENTRY);
	assign key_ra = (cmd.op == OP_SCAN) ? scan_idx_q : node_idx;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_NEW_ENTRY) begin
			key_mem[node_idx] <= key_in;
		end
		if (key_re) begin
			key_rd_q <= key_mem[key_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_SET_BYTES) begin
			bytes_mem[node_idx] <= req_q.tile_bytes;
		end
		if (cmd.op == OP_RD_ENTRY) begin
			bytes_rd_q <= bytes_mem[node_idx];
		end
	end

	always_comb begin
		users_we = 1'b1;
		case (cmd.op)
			OP_NEW_ENTRY:  users_wd = '0;
			OP_MARK_USERS: users_wd = users_rd_q | ubit;
			OP_CLR_USERS:  users_wd = users_rd_q & ~ubit;
			default: begin
				users_we = 1'b0;
				users_wd = users_rd_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (users_we) begin
			users_mem[node_idx] <= users_wd;
		end
		if (cmd.op == OP_RD_ENTRY) begin
			users_rd_q <= users_mem[node_idx];
		end
	end

	// Link updates. The sentinel's own links live in registers, not in the memories.
	always_comb begin
		pw_en   = 1'b0;
		nw_en   = 1'b0;
		pw_addr = node_q;
		pw_data = node_q;
		nw_addr = node_q;
		nw_data = node_q;
		head_d  = head_q;
		tail_d  = tail_q;
		case (cmd.op)
			OP_DETACH_WR: begin
				if (prv_rd_q != NIL) begin
					nw_en   = 1'b1;
					nw_addr = prv_rd_q;
					nw_data = nxt_rd_q;
				end
				if (nxt_rd_q != NIL) begin
					pw_en   = 1'b1;
					pw_addr = nxt_rd_q;
					pw_data = prv_rd_q;
				end
				if (head_q == node_q) begin
					head_d = (nxt_rd_q != NIL) ? nxt_rd_q : SENT;
				end
				if (tail_q == node_q) begin
					tail_d = (prv_rd_q != NIL) ? prv_rd_q : SENT;
				end
			end
			OP_INS_W1: begin
				pw_en   = 1'b1;
				nw_en   = 1'b1;
				pw_data = after_q ? anc_q : prv_rd_q;
				nw_data = after_q ? nxt_rd_q : anc_q;
			end
			OP_INS_W2: begin
				if (after_q) begin
					pw_en   = (nxt_rd_q != NIL);
					pw_addr = nxt_rd_q;
					nw_en   = 1'b1;
					nw_addr = anc_q;
					if (tail_q == anc_q) begin
						tail_d = node_q;
					end
				end else begin
					nw_en   = (prv_rd_q != NIL);
					nw_addr = prv_rd_q;
					pw_en   = 1'b1;
					pw_addr = anc_q;
					if (head_q == anc_q) begin
						head_d = node_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign lr_en   = (cmd.op == OP_LK_RD) || (cmd.op == OP_LK_RD_ANC);
	assign lr_addr = (cmd.op == OP_LK_RD_ANC) ? anc_q : node_q;

	always_ff @(posedge clk) begin
		if (pw_en && (pw_addr != SENT)) begin
			prev_mem[pw_addr[IW-1:0]] <= pw_data;
		end
		if (lr_en) begin
			prv_rd_q <= (lr_addr == SENT) ? sent_prev_q : prev_mem[lr_addr[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (nw_en && (nw_addr != SENT)) begin
			next_mem[nw_addr[IW-1:0]] <= nw_data;
		end
		if (lr_en) begin
			nxt_rd_q <= (lr_addr == SENT) ? sent_next_q : next_mem[lr_addr[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			head_q       <= SENT;
			tail_q       <= SENT;
			sent_prev_q  <= NIL;
			sent_next_q  <= NIL;
			node_q       <= '0;
			anc_q        <= SENT;
			after_q      <= 1'b1;
			scan_idx_q   <= '0;
			scan_s1      <= '0;
			scan_more_q  <= 1'b0;
			s1_act_q     <= 1'b0;
			free_found_q <= 1'b0;
			free_slot_q  <= '0;
			cl_idx_q     <= '0;
			total_q      <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (pw_en && (pw_addr == SENT)) begin
				sent_prev_q <= pw_data;
			end
			if (nw_en && (nw_addr == SENT)) begin
				sent_next_q <= nw_data;
			end

			case (cmd.op)
				OP_SCAN_START: begin
					scan_idx_q   <= '0;
					scan_more_q  <= 1'b1;
					s1_act_q     <= 1'b0;
					free_found_q <= 1'b0;
				end
				OP_SCAN: begin
					// Key reads run one slot ahead of the compare.
					s1_act_q <= scan_more_q;
					if (scan_more_q) begin
						scan_s1     <= scan_idx_q;
						scan_more_q <= (scan_idx_q != LAST_IDX);
						scan_idx_q  <= scan_idx_q + 1'b1;
					end
					if (hit_now) begin
						node_q <= NW'(scan_s1);
					end
					if (s1_act_q && !valid_q[scan_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_slot_q  <= scan_s1;
					end
				end
				OP_SEL_FREE: node_q <= NW'(free_slot_q);
				OP_SEL_HEAD: node_q <= head_q;
				OP_SEL_CL:   node_q <= NW'(cl_idx_q);
				OP_SUB_BYTES: total_q <= sub_res;
				OP_NEW_ENTRY: begin
					valid_q[node_idx] <= 1'b1;
					count_q           <= count_q + 1'b1;
				end
				OP_SET_BYTES: total_q <= total_q + TOTAL_W'(req_q.tile_bytes);
				OP_RELEASE: begin
					valid_q[node_idx] <= 1'b0;
					total_q           <= sub_res;
					if (count_q != '0) begin
						count_q <= count_q - 1'b1;
					end
				end
				OP_ANC_SENT_AFTER: begin
					anc_q   <= SENT;
					after_q <= 1'b1;
				end
				OP_ANC_SENT_BEFORE: begin
					anc_q   <= SENT;
					after_q <= 1'b0;
				end
				OP_ANC_TAIL_AFTER: begin
					anc_q   <= tail_q;
					after_q <= 1'b1;
				end
				OP_CL_START: cl_idx_q <= '0;
				OP_CL_INC:   cl_idx_q <= cl_idx_q + 1'b1;
				default: ;
			endcase

			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_q.status        <= cmd.evict ? ST_OK : cmd.status;
			out_q.evicted_valid <= cmd.evict;
			out_q.evicted_key   <= cmd.evict ? KEY_W'(key_rd_q[KIN-1:0]) : '0;
			out_q.total_bytes   <= total_q;
			out_q.tile_count    <= CNT_W'(count_q);
			out_q.last          <= cmd.evict ? !evict_more : 1'b1;
		end
	end

	assign rsp_out   = out_q;
	assign rsp_valid = out_valid_q;
endmodule

>>> sv/partitioned_lru_byte_budget_list.sv
// Partitioned LRU tile list with a byte budget. Requests are taken one at a time; a
// result register lets the next request in while a result waits. Add, mark and drop
// first search the keys one slot per cycle, then update entries and links in separate
// steps, since every memory has one read and one write port. Clear visits every slot.
// Free gives one result per evicted tile. Any result step waits while the previous
// result is still held by the receiver.
module partitioned_lru_byte_budget_list #(
	parameter int ENTRIES  = plbbl_pkg::DEF_ENTRIES,
	parameter int USERS    = plbbl_pkg::DEF_USERS,
	parameter int KEY_BITS = plbbl_pkg::DEF_KEY_BITS
) (
	input logic         clk,
	input logic         arst_n,
	plbbl_req_if.sink   req,
	plbbl_rsp_if.source rsp
);
	import plbbl_pkg::*;

	req_t     req_in;
	rsp_t     rsp_out;
	ctl_cmd_t cmd;
	dp_stat_t stat;
	logic     in_ready;
	logic     rsp_valid;

	assign req_in = '{mode: req.mode, tile_key: req.tile_key, tile_bytes: req.tile_bytes,
		user_id: req.user_id, byte_budget: req.byte_budget};

	plbbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	plbbl_dp #(
		.ENTRIES  (ENTRIES),
		.USERS    (USERS),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_in    (req_in),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_out   (rsp_out),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready)
	);

	assign req.ready         = in_ready;
	assign rsp.valid         = rsp_valid;
	assign rsp.status        = rsp_out.status;
	assign rsp.evicted_valid = rsp_out.evicted_valid;
	assign rsp.evicted_key   = rsp_out.evicted_key;
	assign rsp.total_bytes   = rsp_out.total_bytes;
	assign rsp.tile_count    = rsp_out.tile_count;
	assign rsp.last          = rsp_out.last;
endmodule

>>> sv/plbbl_chk.sv
// Port checker for the partitioned LRU tile list, bound to the top level.
// Depends on plbbl_pkg and on the top level's result ports.
module plbbl_chk #(
	parameter int ENTRIES = plbbl_pkg::DEF_ENTRIES
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [plbbl_pkg::STAT_W-1:0] rsp_status,
	input logic                       rsp_ev,
	input logic [plbbl_pkg::KEY_W-1:0]  rsp_key,
	input logic [plbbl_pkg::CNT_W-1:0]  rsp_count,
	input logic                       rsp_last
);
	import plbbl_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key) && $stable(rsp_last))
		else $error("result changed while stalled");

	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ev |-> rsp_last && (rsp_key == '0))
		else $error("non-eviction item must be final with a zero key");

	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ev |-> (rsp_status == ST_OK))
		else $error("eviction item with error status");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp_count) <= ENTRIES))
		else $error("tile count above capacity");
endmodule

bind partitioned_lru_byte_budget_list plbbl_chk #(.ENTRIES(ENTRIES)) u_plbbl_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_ev     (rsp.evicted_valid),
	.rsp_key    (rsp.evicted_key),
	.rsp_count  (rsp.tile_count),
	.rsp_last   (rsp.last)
);

>>> tb/partitioned_lru_byte_budget_list_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the partitioned LRU tile list with a byte budget.
// Depends on plbbl_pkg, plbbl_req_if, plbbl_rsp_if and the block itself.
module partitioned_lru_byte_budget_list_tb;
	import plbbl_pkg::*;

	localparam int ENTRIES = DEF_ENTRIES;
	localparam int USERS   = DEF_USERS;
	localparam int SENT    = ENTRIES;
	localparam int NIL     = ENTRIES + 1;
	localparam int LIMIT   = 2000000;
	localparam int N_RAND  = 190;
	localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

	typedef struct {
		req_t rq;
		bit   typed;
		rsp_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	plbbl_req_if req ();
	plbbl_rsp_if rsp ();

	partitioned_lru_byte_budget_list u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the tile list.
	bit                 tl_valid [ENTRIES];
	logic [KEY_W-1:0]   tl_key   [ENTRIES];
	logic [BYTES_W-1:0] tl_bytes [ENTRIES];
	logic [15:0]        tl_users [ENTRIES];
	int                 tl_prev  [ENTRIES+1];
	int                 tl_next  [ENTRIES+1];
	int                 tl_head, tl_tail;
	logic [TOTAL_W-1:0] tl_total;
	int                 tl_count;

	rsp_t expected_rsp_q[$];
	logic [KEY_W-1:0] key_pool[24];
	int  errors = 0;
	int  cyc = 0;
	bit  quiet = 1'b0;
	bit  hold_go = 1'b0;
	bit  hold_done = 1'b0;
	int  stall_left = 0;

	function automatic void list_detach(int n);
		int p, q;
		p = tl_prev[n];
		q = tl_next[n];
		if (p != NIL) tl_next[p] = q;
		if (q != NIL) tl_prev[q] = p;
		if (tl_head == n) tl_head = (q != NIL) ? q : SENT;
		if (tl_tail == n) tl_tail = (p != NIL) ? p : SENT;
		tl_prev[n] = NIL;
		tl_next[n] = NIL;
	endfunction

	function automatic void list_after(int a, int n);
		int q;
		q = tl_next[a];
		tl_prev[n] = a;
		tl_next[n] = q;
		if (q != NIL) tl_prev[q] = n;
		tl_next[a] = n;
		if (tl_tail == a) tl_tail = n;
	endfunction

	function automatic void list_before(int b, int n);
		int p;
		p = tl_prev[b];
		tl_next[n] = b;
		tl_prev[n] = p;
		if (p != NIL) tl_next[p] = n;
		tl_prev[b] = n;
		if (tl_head == b) tl_head = n;
	endfunction

	function automatic int find_tile(logic [KEY_W-1:0] k);
		for (int i = 0; i < ENTRIES; i++)
			if (tl_valid[i] && tl_key[i] == k) return i;
		return NIL;
	endfunction

	function automatic void take_bytes(logic [BYTES_W-1:0] b);
		tl_total = (tl_total >= TOTAL_W'(b)) ? tl_total - TOTAL_W'(b) : '0;
	endfunction

	function automatic rsp_t tile_rsp(logic [STAT_W-1:0] st, logic ev,
			logic [KEY_W-1:0] k, logic lst);
		rsp_t o;
		o.status = st;
		o.evicted_valid = ev;
		o.evicted_key = k;
		o.total_bytes = tl_total;
		o.tile_count = CNT_W'(tl_count);
		o.last = lst;
		return o;
	endfunction

	function automatic void reset_tiles();
		for (int i = 0; i < ENTRIES; i++) tl_valid[i] = 1'b0;
		for (int i = 0; i <= ENTRIES; i++) begin
			tl_prev[i] = NIL;
			tl_next[i] = NIL;
		end
		tl_head = SENT;
		tl_tail = SENT;
		tl_total = '0;
		tl_count = 0;
	endfunction

	// Applies one request to the shadow list and queues the results it causes.
	function automatic void predict_tiles(req_t r);
		int s, k, v;
		logic [15:0] ub;
		ub = (r.user_id < USERS) ? (16'd1 << r.user_id) : 16'd0;
		case (r.mode)
			MODE_ADD: begin
				s = find_tile(r.tile_key);
				if (s == NIL) begin
					for (s = 0; s < ENTRIES; s++)
						if (!tl_valid[s]) break;
					if (s == ENTRIES) begin
						expected_rsp_q.push_back(tile_rsp(ST_FULL, 1'b0, '0, 1'b1));
						return;
					end
					tl_valid[s] = 1'b1;
					tl_key[s] = r.tile_key;
					tl_users[s] = '0;
					tl_count++;
				end else begin
					take_bytes(tl_bytes[s]);
					list_detach(s);
				end
				tl_bytes[s] = r.tile_bytes;
				tl_total = tl_total + TOTAL_W'(r.tile_bytes);
				list_after(SENT, s);
				expected_rsp_q.push_back(tile_rsp(ST_OK, 1'b0, '0, 1'b1));
			end
			MODE_MARK: begin
				s = find_tile(r.tile_key);
				if (s == NIL) begin
					expected_rsp_q.push_back(tile_rsp(ST_NOT_FOUND, 1'b0, '0, 1'b1));
					return;
				end
				tl_users[s] |= ub;
				if (tl_tail != s) begin
					list_detach(s);
					list_after(tl_tail, s);
				end
				expected_rsp_q.push_back(tile_rsp(ST_OK, 1'b0, '0, 1'b1));
			end
			MODE_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (!tl_valid[i]) continue;
					tl_users[i] &= ~ub;
					if (tl_users[i] == 0) begin
						list_detach(i);
						list_before(SENT, i);
					end
				end
				expected_rsp_q.push_back(tile_rsp(ST_OK, 1'b0, '0, 1'b1));
			end
			MODE_FREE: begin
				k = 0;
				while (tl_total > r.byte_budget && tl_head != SENT) begin
					v = tl_head;
					list_detach(v);
					take_bytes(tl_bytes[v]);
					if (tl_count > 0) tl_count--;
					tl_valid[v] = 1'b0;
					expected_rsp_q.push_back(tile_rsp(ST_OK, 1'b1, tl_key[v], 1'b0));
					k++;
				end
				if (k == 0) expected_rsp_q.push_back(tile_rsp(ST_OK, 1'b0, '0, 1'b1));
				else expected_rsp_q[$].last = 1'b1;
			end
			MODE_DROP: begin
				s = find_tile(r.tile_key);
				if (s == NIL) begin
					expected_rsp_q.push_back(tile_rsp(ST_NOT_FOUND, 1'b0, '0, 1'b1));
					return;
				end
				list_detach(s);
				take_bytes(tl_bytes[s]);
				if (tl_count > 0) tl_count--;
				tl_valid[s] = 1'b0;
				expected_rsp_q.push_back(tile_rsp(ST_OK, 1'b0, '0, 1'b1));
			end
			default: expected_rsp_q.push_back(tile_rsp(ST_OK, 1'b0, '0, 1'b1));
		endcase
	endfunction

	function automatic req_t tile_req(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
			logic [BYTES_W-1:0] b, logic [USER_W-1:0] u, logic [TOTAL_W-1:0] bud);
		req_t r;
		r.mode = m;
		r.tile_key = k;
		r.tile_bytes = b;
		r.user_id = u;
		r.byte_budget = bud;
		return r;
	endfunction

	function automatic rsp_t plain_rsp(logic [STAT_W-1:0] st, logic [TOTAL_W-1:0] tot,
			int cnt);
		rsp_t o;
		o.status = st;
		o.evicted_valid = 1'b0;
		o.evicted_key = '0;
		o.total_bytes = tot;
		o.tile_count = CNT_W'(cnt);
		o.last = 1'b1;
		return o;
	endfunction

	function automatic req_t random_req();
		int pick;
		req_t r;
		pick = $urandom_range(0, 99);
		r.tile_key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 23)]
			: $urandom;
		r.tile_bytes = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 4095);
		r.user_id = USER_W'($urandom_range(0, 15));
		if ($urandom_range(0, 1)) begin
			r.byte_budget = TOTAL_W'({$urandom, $urandom});
		end else begin
			r.byte_budget = tl_total - TOTAL_W'($urandom_range(0, 20000));
			if (r.byte_budget > tl_total) r.byte_budget = '0;
		end
		if (pick < 35) r.mode = MODE_ADD;
		else if (pick < 55) r.mode = MODE_MARK;
		else if (pick < 63) r.mode = MODE_CLEAR;
		else if (pick < 78) r.mode = MODE_FREE;
		else if (pick < 96) r.mode = MODE_DROP;
		else r.mode = MODE_SPARE_LO + MODE_W'($urandom_range(0, 2));
		return r;
	endfunction

	// Offers one item and applies it to the shadow list once it is accepted.
	task automatic send_tile(req_t r);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.mode <= r.mode;
		req.tile_key <= r.tile_key;
		req.tile_bytes <= r.tile_bytes;
		req.user_id <= r.user_id;
		req.byte_budget <= r.byte_budget;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_tiles(r);
	endtask

	// Result side: random stalls, one long hold-off, and the field checks.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsp_q.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, rsp.status);
					errors++;
				end
				if (rsp.evicted_valid !== want.evicted_valid) begin
					$error("evicted_valid expected %0d got %0d", want.evicted_valid,
						rsp.evicted_valid);
					errors++;
				end
				if (rsp.evicted_key !== want.evicted_key) begin
					$error("evicted_key expected %h got %h", want.evicted_key,
						rsp.evicted_key);
					errors++;
				end
				if (rsp.total_bytes !== want.total_bytes) begin
					$error("total_bytes expected %0d got %0d", want.total_bytes,
						rsp.total_bytes);
					errors++;
				end
				if (rsp.tile_count !== want.tile_count) begin
					$error("tile_count expected %0d got %0d", want.tile_count,
						rsp.tile_count);
					errors++;
				end
				if (rsp.last !== want.last) begin
					$error("last expected %0d got %0d", want.last, rsp.last);
					errors++;
				end
			end
		end
		if (hold_go && !hold_done) begin
			stall_left = 400;
			hold_done = 1'b1;
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 19);
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT) begin
			$display("partitioned_lru_byte_budget_list_tb NOT OK");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t rw;
		req_t r;
		req.valid = 1'b0;
		req.mode = '0;
		req.tile_key = '0;
		req.tile_bytes = '0;
		req.user_id = '0;
		req.byte_budget = '0;
		rsp.ready = 1'b0;
		reset_tiles();
		for (int i = 0; i < 24; i++) key_pool[i] = $urandom;

		rw.typed = 1'b1;
		rw.rq = tile_req(MODE_FREE, '0, '0, '0, '0);
		rw.want = plain_rsp(ST_OK, '0, 0); rows.push_back(rw);
		rw.rq = tile_req(MODE_DROP, 32'd5, '0, '0, '0);
		rw.want = plain_rsp(ST_NOT_FOUND, '0, 0); rows.push_back(rw);
		rw.rq = tile_req(MODE_MARK, 32'd5, '0, 4'd3, '0);
		rw.want = plain_rsp(ST_NOT_FOUND, '0, 0); rows.push_back(rw);
		rw.rq = tile_req(MODE_SPARE_HI, '1, '1, '1, '1);
		rw.want = plain_rsp(ST_OK, '0, 0); rows.push_back(rw);
		rw.rq = tile_req(MODE_ADD, '0, '1, '0, '0);
		rw.want = plain_rsp(ST_OK, 38'hFFFFFFFF, 1); rows.push_back(rw);
		rw.typed = 1'b0;
		rw.rq = tile_req(MODE_ADD, '1, '0, '0, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_ADD, 32'hA5A5A5A5, 32'd100, '0, '0); rows.push_back(rw);
		// Re-adding a present tile replaces its bytes.
		rw.rq = tile_req(MODE_ADD, '0, 32'd10, '0, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_MARK, '1, '0, 4'd15, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_MARK, 32'hA5A5A5A5, '0, 4'd0, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_MARK, 32'hA5A5A5A5, '0, 4'd1, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_MARK, '1, '0, 4'd15, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_CLEAR, '0, '0, 4'd15, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_CLEAR, '0, '0, 4'd0, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_FREE, '0, '0, '0, '1); rows.push_back(rw);
		rw.rq = tile_req(MODE_ADD, 32'h12345678, 32'h80000000, '0, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_SPARE_LO, '0, '0, '0, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_SPARE_MID, 32'h5A5A5A5A, '1, 4'd9, 38'h2A_AAAA_AAAA);
		rows.push_back(rw);
		rw.rq = tile_req(MODE_FREE, '0, '0, '0, 38'd50); rows.push_back(rw);
		rw.rq = tile_req(MODE_FREE, '0, '0, '0, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_DROP, '0, '0, '0, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_ADD, 32'd1, 32'd5, '0, '0); rows.push_back(rw);
		rw.rq = tile_req(MODE_DROP, 32'd1, '0, '0, '0); rows.push_back(rw);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_tile(rows[i].rq);
			if (rows[i].typed) begin
				void'(expected_rsp_q.pop_back());
				expected_rsp_q.push_back(rows[i].want);
			end
		end

		for (int n = 0; n < N_RAND; n++) begin
			if (n == 20) hold_go = 1'b1;
			if (n == N_RAND - 40) quiet = 1'b1;
			if (n == 60) begin
				// Fill the table past its capacity, then free it down.
				for (int j = 0; j < ENTRIES + 2; j++)
					send_tile(tile_req(MODE_ADD, $urandom, $urandom_range(0, 65535),
						USER_W'($urandom_range(0, 15)), '0));
				send_tile(tile_req(MODE_FREE, '0, '0, '0,
					TOTAL_W'({$urandom, $urandom} >> 20)));
				n += ENTRIES + 2;
			end
			r = random_req();
			send_tile(r);
		end
		req.valid <= 1'b0;

		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("partitioned_lru_byte_budget_list_tb OK");
		else $display("partitioned_lru_byte_budget_list_tb NOT OK");
		$finish;
	end

endmodule

>>> files.f
sv/plbbl_pkg.sv
sv/plbbl_req_if.sv
sv/plbbl_rsp_if.sv
sv/plbbl_ctrl.sv
sv/plbbl_dp.sv
sv/partitioned_lru_byte_budget_list.sv
sv/plbbl_chk.sv
tb/partitioned_lru_byte_budget_list_tb.sv
